FILE: sv/sdf_pkg.sv
// Shared types, constants and helpers for the smooth damp follower.
package sdf_pkg;
    localparam int VW = 32;
    localparam int FB = 16;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE = VW'(64'sd1 <<< FB);
    localparam logic signed [VW-1:0] EPS = VW'(((64'sd1 <<< FB) + 5000) / 10000);
    localparam logic signed [VW-1:0] C048 = VW'((48 * (64'sd1 <<< FB) + 50) / 100);
    localparam logic signed [VW-1:0] C0235 = VW'((235 * (64'sd1 <<< FB) + 500) / 1000);
    localparam logic signed [VW+1:0] FULL = (VW+2)'(64'sd360 <<< FB);
    localparam logic signed [VW+1:0] HALF = (VW+2)'(64'sd180 <<< FB);
    // angle reduction: offset that makes any difference positive, and the last modulus step
    localparam logic signed [VW+2:0] WBASE = (VW+3)'(64'sd360 <<< (FB + 8));
    localparam logic signed [VW+2:0] WLAST = (VW+3)'(64'sd360 <<< FB);
    localparam int QW = 2 * FB + 2;
    localparam logic [1:0] REG_ST = 2'd0;
    localparam logic [1:0] REG_MS = 2'd1;
    localparam logic [1:0] REG_DT = 2'd2;
    localparam logic [1:0] REG_AM = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_WRAP1, S_WRAP2, S_OMEGA, S_OMW, S_X, S_X2, S_X3, S_D1, S_D2,
        S_DEN, S_DCW, S_LIM, S_CHG, S_T1, S_TMP, S_V1, S_VEL, S_N1, S_NEXT, S_OUT
    } state_t;

    typedef struct packed {
        state_t step;
        logic   load;
        logic   div_start;
    } sdf_cmd_t;

    typedef struct packed {
        logic div_done;
        logic wrap_done;
    } sdf_sts_t;

    function automatic logic signed [VW-1:0] sat(input logic signed [VW+1:0] v);
        if (v > (VW+2)'(VMAX)) return VMAX;
        if (v < (VW+2)'(VMIN)) return VMIN;
        return v[VW-1:0];
    endfunction
endpackage

FILE: sv/smooth_damp_follower.sv
// Top level of the critically damped smooth damp follower.
//
// Input channel s_axis: tdata = current_position [31:0], target_position [63:32].
// Result channel m_axis: tdata = next_position [31:0], new_velocity [63:32];
// tuser = snapped. Configuration: cfg_valid/cfg_ready with cfg_index and
// cfg_data; index 0 smooth_time, 1 max_speed, 2 delta_time, 3 angle_mode,
// others ignored.
// One item at a time: the block takes no new item while one is in progress.
// The time is set by the angle reduction, the two bit-serial divisions (omega
// and decay, 34 quotient bits each) and the shared multiplier which serves
// eleven products one per cycle.
// The result sits in an output register; a new item is taken once the
// previous result is stored there, and the block holds its final step
// while the receiver stalls with a full register.
// Reset restores register defaults and clears the velocity.
module smooth_damp_follower import sdf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // current_position, target_position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // next_position, new_velocity
    output logic [0:0]  m_tuser,   // snapped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    logic [VW-2:0] st_reg, ms_reg, dt_reg;
    logic          am_reg, mv_reg, out_set;
    sdf_cmd_t      cmd;
    sdf_sts_t      sts;
    logic signed [VW-1:0] nq, vq;
    logic          sq;

    assign cfg_ready = 1'b1;

    // write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= 31'd65536; ms_reg <= 31'h7FFFFFFF; dt_reg <= 31'd1092; am_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ST: st_reg <= cfg_data[30:0];
                REG_MS: ms_reg <= cfg_data[30:0];
                REG_DT: dt_reg <= cfg_data[30:0];
                REG_AM: am_reg <= cfg_data[0];
            endcase
        end
    end

    sdf_ctrl u_ctrl (.aclk(aclk), .aresetn(aresetn), .in_fire(s_tvalid && s_tready),
                     .out_busy(mv_reg && !m_tready), .sts(sts), .cmd(cmd),
                     .in_ready(s_tready), .out_set(out_set));

    sdf_dp u_dp (.aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
                 .cur_in(s_tdata[31:0]), .tgt_in(s_tdata[63:32]), .st_cfg(st_reg),
                 .ms_cfg(ms_reg), .dt_cfg(dt_reg), .am_cfg(am_reg), .out_set(out_set),
                 .next_q(nq), .vel_q(vq), .snap_q(sq));

    // hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) mv_reg <= 1'b0;
        else if (out_set) mv_reg <= 1'b1;
        else if (m_tready) mv_reg <= 1'b0;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = {vq, nq};
    assign m_tuser = sq;
endmodule

FILE: sv/sdf_ctrl.sv
// Sequencer for one follower step.
module sdf_ctrl import sdf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_fire,
    input  logic     out_busy,
    input  sdf_sts_t sts,
    output sdf_cmd_t cmd,
    output logic     in_ready,
    output logic     out_set
);
    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // advance through the steps
    always_comb begin
        state_next = state_reg;
        cmd.step = state_reg;
        cmd.load = 1'b0;
        cmd.div_start = 1'b0;
        in_ready = (state_reg == S_IDLE);
        out_set = 1'b0;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin
                cmd.load = 1'b1;
                state_next = S_WRAP1;
            end
            S_WRAP1: if (sts.wrap_done) state_next = S_WRAP2;
            S_OMEGA: begin
                cmd.div_start = 1'b1;
                state_next = S_OMW;
            end
            S_OMW: if (sts.div_done) state_next = S_X;
            S_DEN: begin
                cmd.div_start = 1'b1;
                state_next = S_DCW;
            end
            S_DCW: if (sts.div_done) state_next = S_LIM;
            S_OUT: if (!out_busy) begin
                out_set = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = state_t'(state_reg + 5'd1);
        endcase
    end
endmodule

FILE: sv/sdf_div.sv
// Restoring divider, one quotient bit a cycle, rounded to nearest.
module sdf_div import sdf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [QW-1:0]     num,
    input  logic [VW-2:0]     den,
    output logic              done,
    output logic [VW-1:0]     quo
);
    localparam int CW = $clog2(QW + 1);
    logic [QW-1:0] n_reg, q_reg;
    logic [VW-1:0] r_reg;
    logic [VW-2:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [VW:0]   trial;
    logic [VW-1:0] sh;
    logic [QW:0]   qr;

    assign sh = {r_reg[VW-2:0], n_reg[QW-1]};
    assign trial = {1'b0, sh} - {2'b0, d_reg};
    assign done = busy_reg && (cnt_reg == '0);
    // round by the remainder: 2r >= d adds one
    assign qr = {1'b0, q_reg} + (QW+1)'({1'b0, r_reg, 1'b0} >= {2'b0, d_reg});
    assign quo = (qr > (QW+1)'(VMAX)) ? VMAX : qr[VW-1:0];

    // shift one bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= CW'(QW);
            n_reg <= num;
            d_reg <= den;
            r_reg <= '0;
            q_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == '0) busy_reg <= 1'b0;
            else begin
                cnt_reg <= cnt_reg - 1'b1;
                n_reg <= {n_reg[QW-2:0], 1'b0};
                if (!trial[VW]) begin
                    r_reg <= trial[VW-1:0];
                    q_reg <= {q_reg[QW-2:0], 1'b1};
                end else begin
                    r_reg <= sh;
                    q_reg <= {q_reg[QW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

FILE: sv/sdf_dp.sv
// Datapath: shared multiplier, adders, divider and result registers.
module sdf_dp import sdf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdf_cmd_t             cmd,
    output sdf_sts_t             sts,
    input  logic signed [VW-1:0] cur_in,
    input  logic signed [VW-1:0] tgt_in,
    input  logic [VW-2:0]        st_cfg,
    input  logic [VW-2:0]        ms_cfg,
    input  logic [VW-2:0]        dt_cfg,
    input  logic                 am_cfg,
    input  logic                 out_set,
    output logic signed [VW-1:0] next_q,
    output logic signed [VW-1:0] vel_q,
    output logic                 snap_q
);
    logic signed [VW-1:0] cur_reg, tgt_reg, vel_reg, om_reg, dt_reg, st_reg, ms_reg;
    logic signed [VW-1:0] x_reg, x2_reg, x3_reg, den_reg, dec_reg, chg_reg, lim_reg;
    logic signed [VW-1:0] tmp_reg, acc_reg, nx_reg, vn_reg, base_reg;
    logic signed [VW+2:0] wv_reg, fm_reg, wdiff;
    logic                 am_reg;
    logic signed [VW-1:0] ma, mb, mr;
    logic [2*VW-1:0]      pm;
    logic [VW-1:0]        mga, mgb;
    logic [2*VW-FB:0]     rnd;
    logic                 neg;
    logic [QW-1:0]        dnum;
    logic [VW-2:0]        dden;
    logic [VW-1:0]        dq;
    logic signed [VW+1:0] d, dd;
    logic                 snap;
    logic                 div_done;

    sdf_div u_div (.aclk(aclk), .aresetn(aresetn), .start(cmd.div_start), .num(dnum),
                   .den(dden), .done(div_done), .quo(dq));

    // report divider and angle reduction completion
    assign sts = {div_done, fm_reg == WLAST};

    // select multiplier operands per step
    always_comb begin
        ma = x_reg; mb = x_reg;
        unique case (cmd.step)
            S_X:    begin ma = om_reg; mb = dt_reg; end
            S_X2:   begin ma = x_reg;  mb = x_reg;  end
            S_X3:   begin ma = x2_reg; mb = x_reg;  end
            S_D1:   begin ma = C048;   mb = x2_reg; end
            S_D2:   begin ma = C0235;  mb = x3_reg; end
            S_LIM:  begin ma = ms_reg; mb = st_reg; end
            S_T1:   begin ma = om_reg; mb = chg_reg; end
            S_TMP:  begin ma = acc_reg; mb = dt_reg; end
            S_V1:   begin ma = om_reg; mb = tmp_reg; end
            S_VEL:  begin ma = acc_reg; mb = dec_reg; end
            S_N1:   begin ma = acc_reg; mb = dec_reg; end
            default: ;
        endcase
        neg = ma[VW-1] ^ mb[VW-1];
        mga = ma[VW-1] ? VW'(-ma) : VW'(ma);
        mgb = mb[VW-1] ? VW'(-mb) : VW'(mb);
        pm = mga * mgb;
        rnd = (2*VW-FB+1)'((pm + (2*VW)'(64'd1 << (FB-1))) >> FB);
        if (!neg) mr = (rnd > (2*VW-FB+1)'(VMAX)) ? VMAX : rnd[VW-1:0];
        else if (rnd > (2*VW-FB+1)'(VMAX) + 1'b1) mr = VMIN;
        else mr = VW'(-rnd[VW-1:0]);
        dnum = (cmd.step == S_OMEGA) ? QW'(2) << (2*FB) : QW'(1) << (2*FB);
        dden = (cmd.step == S_OMEGA) ? st_reg[VW-2:0]
             : (den_reg < 1 ? (VW-1)'(1) : den_reg[VW-2:0]);
        wdiff = (VW+3)'(tgt_in) - (VW+3)'(cur_in) + WBASE;
        d = (VW+2)'(wv_reg);
        dd = (d > HALF) ? d - FULL : d;
        snap = ((tgt_reg > cur_reg) == (nx_reg > tgt_reg));
    end

    // register each step's result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg <= '0;
        end else begin
            unique case (cmd.step)
                S_IDLE: if (cmd.load) begin
                    cur_reg <= cur_in; tgt_reg <= tgt_in;
                    st_reg <= (signed'({1'b0, st_cfg}) < EPS) ? EPS : signed'({1'b0, st_cfg});
                    ms_reg <= signed'({1'b0, ms_cfg});
                    dt_reg <= signed'({1'b0, dt_cfg});
                    am_reg <= am_cfg;
                    wv_reg <= wdiff;
                    fm_reg <= WBASE;
                end
                // reduce the difference modulo 360 degrees, one compare and subtract a cycle
                S_WRAP1: begin
                    if (wv_reg >= fm_reg) wv_reg <= wv_reg - fm_reg;
                    fm_reg <= fm_reg >>> 1;
                end
                S_WRAP2: begin
                    if (am_reg) tgt_reg <= sat((VW+2)'(cur_reg) + dd);
                end
                S_OMW: if (sts.div_done) om_reg <= dq;
                S_X:  x_reg <= mr;
                S_X2: x2_reg <= mr;
                S_X3: begin
                    x3_reg <= mr;
                    den_reg <= sat((VW+2)'(ONE) + (VW+2)'(x_reg));
                end
                S_D1: den_reg <= sat((VW+2)'(den_reg) + (VW+2)'(mr));
                S_D2: den_reg <= sat((VW+2)'(den_reg) + (VW+2)'(mr));
                S_DCW: if (sts.div_done) dec_reg <= dq;
                S_LIM: begin
                    lim_reg <= mr;
                    chg_reg <= sat((VW+2)'(cur_reg) - (VW+2)'(tgt_reg));
                end
                S_CHG: begin
                    if (chg_reg > lim_reg) chg_reg <= lim_reg;
                    else if (chg_reg < -lim_reg) chg_reg <= -lim_reg;
                end
                S_T1: begin
                    acc_reg <= sat((VW+2)'(vel_reg) + (VW+2)'(mr));
                    base_reg <= sat((VW+2)'(cur_reg) - (VW+2)'(chg_reg));
                end
                S_TMP: tmp_reg <= mr;
                S_V1: acc_reg <= sat((VW+2)'(vel_reg) - (VW+2)'(mr));
                S_VEL: begin
                    vn_reg <= mr;
                    acc_reg <= sat((VW+2)'(chg_reg) + (VW+2)'(tmp_reg));
                end
                S_N1: nx_reg <= sat((VW+2)'(base_reg) + (VW+2)'(mr));
                // load the output register only once the previous item has left
                S_OUT: if (out_set) begin
                    snap_q <= snap;
                    next_q <= snap ? tgt_reg : nx_reg;
                    vel_q <= snap ? '0 : vn_reg;
                    vel_reg <= snap ? '0 : vn_reg;
                end
                default: ;
            endcase
        end
    end
endmodule
